// File: rtl/yrm_pkg.sv
// shared types, coefficients and helpers for the yuyv to rgb red mask core
// no dependencies
package yrm_pkg;

	localparam int NSTAGE = 5;

	localparam logic signed [10:0] K_Y   = 11'sd298;
	localparam logic signed [10:0] K_RV  = 11'sd409;
	localparam logic signed [10:0] K_GU  = 11'sd100;
	localparam logic signed [10:0] K_GV  = 11'sd208;
	localparam logic signed [10:0] K_BU  = 11'sd516;
	localparam logic signed [8:0]  Y_OFS = 9'sd16;
	localparam logic signed [8:0]  C_OFS = 9'sd128;
	localparam logic signed [19:0] ROUND = 20'sd128;

	localparam logic [7:0]         RED_MIN    = 8'd115;
	localparam logic [7:0]         GB_MAX     = 8'd63;
	localparam logic signed [12:0] HUE_LIMIT  = 13'sd1275;
	localparam logic [7:0]         CHAN_MAX   = 8'd255;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// load enables, one per pipeline stage
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

	// true when v is not a multiple of 3 (base-4 digit sum)
	function automatic logic mod3_nz(input logic [10:0] v);
		logic [11:0] w;
		logic [4:0]  s;
		w = {1'b0, v};
		s = '0;
		for (int i = 0; i < 6; i++) begin
			s = s + {3'b000, w[2*i +: 2]};
		end
		return !(s == 5'd0 || s == 5'd3 || s == 5'd6 || s == 5'd9 ||
			s == 5'd12 || s == 5'd15 || s == 5'd18);
	endfunction

endpackage

// File: rtl/yrm_if.sv
// valid/ready channels for yuyv words in and rgb pixel pairs out
// no dependencies
interface yrm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] luma0;
	logic [7:0] chroma_u;
	logic [7:0] luma1;
	logic [7:0] chroma_v;
	logic [9:0] column;
	logic [8:0] row;

	modport source (output valid, luma0, chroma_u, luma1, chroma_v, column, row,
		input ready);
	modport sink (input valid, luma0, chroma_u, luma1, chroma_v, column, row,
		output ready);
endinterface

interface yrm_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red0;
	logic [7:0] green0;
	logic [7:0] blue0;
	logic [7:0] red1;
	logic [7:0] green1;
	logic [7:0] blue1;

	modport source (output valid, red0, green0, blue0, red1, green1, blue1,
		input ready);
	modport sink (input valid, red0, green0, blue0, red1, green1, blue1,
		output ready);
endinterface

// File: rtl/yrm_convert.sv
// bt.601 yuv to rgb for one pixel: products, sums, shift and clamp (stages 1-3)
// depends on yrm_pkg
module yrm_convert import yrm_pkg::*; (
	input  logic     clk,
	input  pipe_en_t ld,
	input  logic [7:0] luma,
	input  logic [7:0] chroma_u,
	input  logic [7:0] chroma_v,
	output rgb_t     rgb
);

	logic signed [8:0]  c, d, e;
	logic signed [19:0] py_s1, pr_s1, pgu_s1, pgv_s1, pb_s1;
	logic signed [19:0] accr_s2, accg_s2, accb_s2;
	rgb_t               rgb_s3;

	function automatic logic [7:0] clamp8(input logic signed [19:0] acc);
		logic signed [11:0] q;
		q = 12'(acc >>> 8);
		if (q < 12'sd0) begin
			return 8'd0;
		end else if (q > 12'sd255) begin
			return CHAN_MAX;
		end
		return q[7:0];
	endfunction

	assign c = $signed({1'b0, luma}) - Y_OFS;
	assign d = $signed({1'b0, chroma_u}) - C_OFS;
	assign e = $signed({1'b0, chroma_v}) - C_OFS;

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			py_s1  <= 20'(c) * 20'(K_Y);
			pr_s1  <= 20'(e) * 20'(K_RV);
			pgu_s1 <= 20'(d) * 20'(K_GU);
			pgv_s1 <= 20'(e) * 20'(K_GV);
			pb_s1  <= 20'(d) * 20'(K_BU);
		end
		if (ld.s2) begin
			accr_s2 <= py_s1 + pr_s1 + ROUND;
			accg_s2 <= py_s1 - pgu_s1 - pgv_s1 + ROUND;
			accb_s2 <= py_s1 + pb_s1 + ROUND;
		end
		if (ld.s3) begin
			rgb_s3.red   <= clamp8(accr_s2);
			rgb_s3.green <= clamp8(accg_s2);
			rgb_s3.blue  <= clamp8(accb_s2);
		end
	end

	assign rgb = rgb_s3;

endmodule

// File: rtl/yrm_red_mask.sv
// red detection and position mask for one pixel (stages 4-5)
// depends on yrm_pkg
module yrm_red_mask import yrm_pkg::*; (
	input  logic     clk,
	input  pipe_en_t ld,
	input  rgb_t     rgb_in,
	input  logic     mask_s4,
	output rgb_t     rgb_out
);

	logic [15:0]        rr, gg, bb;
	logic signed [12:0] rs, gs, bs;
	logic [19:0]        rsq_s4;
	logic [18:0]        gbsq_s4;
	logic signed [12:0] lin1_s4, lin2_s4;
	logic               simple_s4;
	rgb_t               rgb_s4, rgb_s5;
	logic               red;

	assign rr = 16'(rgb_in.red) * 16'(rgb_in.red);
	assign gg = 16'(rgb_in.green) * 16'(rgb_in.green);
	assign bb = 16'(rgb_in.blue) * 16'(rgb_in.blue);
	assign rs = $signed({5'b0, rgb_in.red});
	assign gs = $signed({5'b0, rgb_in.green});
	assign bs = $signed({5'b0, rgb_in.blue});

	// 9*r^2 against 4*(g^2+b^2), hue margins against the limit
	always_ff @(posedge clk) begin
		if (ld.s4) begin
			rsq_s4    <= {1'b0, rr, 3'b000} + 20'(rr);
			gbsq_s4   <= {(17'(gg) + 17'(bb)), 2'b00};
			lin1_s4   <= rs * 13'sd10 + bs * 13'sd4 - gs * 13'sd10;
			lin2_s4   <= rs * 13'sd10 + gs * 13'sd4 - bs * 13'sd10;
			simple_s4 <= rgb_in.red >= RED_MIN && rgb_in.green <= GB_MAX &&
				rgb_in.blue <= GB_MAX;
			rgb_s4    <= rgb_in;
		end
	end

	assign red = simple_s4 || (rsq_s4 > 20'(gbsq_s4) && lin1_s4 > HUE_LIMIT &&
		lin2_s4 > HUE_LIMIT);

	always_ff @(posedge clk) begin
		if (ld.s5) begin
			if (mask_s4) begin
				rgb_s5.red   <= 8'd0;
				rgb_s5.green <= red ? CHAN_MAX : 8'd0;
				rgb_s5.blue  <= 8'd0;
			end else begin
				rgb_s5 <= rgb_s4;
			end
		end
	end

	assign rgb_out = rgb_s5;

endmodule

// File: rtl/yuyv_to_rgb_red_mask_core.sv
// yuyv 4:2:2 to rgb core with red mask: five register stages, valid bits per stage
// an accepted input beat moves through stage registers s1 to s5 and leaves from s5
// throughput: one beat per cycle while pix_out.ready holds; each stage loads when empty or when the next one moves
// reset clears all stage valid bits; payload registers are not reset
// depends on yrm_pkg, yrm_if, yrm_convert, yrm_red_mask
module yuyv_to_rgb_red_mask_core import yrm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	yrm_in_if.sink       pix_in,
	yrm_out_if.source    pix_out
);

	logic     v_s1, v_s2, v_s3, v_s4, v_s5;
	pipe_en_t ld;
	logic     mrow, mcol0, mcol1;
	logic     m0_s1, m0_s2, m0_s3, m0_s4, m0_s5;
	logic     m1_s1, m1_s2, m1_s3, m1_s4;
	rgb_t     rgb0_s3, rgb1_s3, rgb0_s5, rgb1_s5;
	logic     accept;

	// ready chain from the output back
	assign ld.s5 = !v_s5 || pix_out.ready;
	assign ld.s4 = !v_s4 || ld.s5;
	assign ld.s3 = !v_s3 || ld.s4;
	assign ld.s2 = !v_s2 || ld.s3;
	assign ld.s1 = !v_s1 || ld.s2;

	assign pix_in.ready = ld.s1;
	assign accept       = pix_in.valid && ld.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (ld.s1) v_s1 <= pix_in.valid;
			if (ld.s2) v_s2 <= v_s1;
			if (ld.s3) v_s3 <= v_s2;
			if (ld.s4) v_s4 <= v_s3;
			if (ld.s5) v_s5 <= v_s4;
		end
	end

	// mask positions: column and row both not multiples of 3
	assign mrow  = mod3_nz(11'(pix_in.row));
	assign mcol0 = mod3_nz(11'(pix_in.column));
	assign mcol1 = mod3_nz(11'(pix_in.column) + 11'd1);

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			m0_s1 <= mcol0 && mrow;
			m1_s1 <= mcol1 && mrow;
		end
		if (ld.s2) begin
			m0_s2 <= m0_s1;
			m1_s2 <= m1_s1;
		end
		if (ld.s3) begin
			m0_s3 <= m0_s2;
			m1_s3 <= m1_s2;
		end
		if (ld.s4) begin
			m0_s4 <= m0_s3;
			m1_s4 <= m1_s3;
		end
		if (ld.s5) begin
			m0_s5 <= m0_s4;
		end
	end

	yrm_convert u_conv0 (
		.clk      (clk),
		.ld       (ld),
		.luma     (pix_in.luma0),
		.chroma_u (pix_in.chroma_u),
		.chroma_v (pix_in.chroma_v),
		.rgb      (rgb0_s3)
	);

	yrm_convert u_conv1 (
		.clk      (clk),
		.ld       (ld),
		.luma     (pix_in.luma1),
		.chroma_u (pix_in.chroma_u),
		.chroma_v (pix_in.chroma_v),
		.rgb      (rgb1_s3)
	);

	yrm_red_mask u_mask0 (
		.clk     (clk),
		.ld      (ld),
		.rgb_in  (rgb0_s3),
		.mask_s4 (m0_s4),
		.rgb_out (rgb0_s5)
	);

	yrm_red_mask u_mask1 (
		.clk     (clk),
		.ld      (ld),
		.rgb_in  (rgb1_s3),
		.mask_s4 (m1_s4),
		.rgb_out (rgb1_s5)
	);

	assign pix_out.valid  = v_s5;
	assign pix_out.red0   = rgb0_s5.red;
	assign pix_out.green0 = rgb0_s5.green;
	assign pix_out.blue0  = rgb0_s5.blue;
	assign pix_out.red1   = rgb1_s5.red;
	assign pix_out.green1 = rgb1_s5.green;
	assign pix_out.blue1  = rgb1_s5.blue;

	a_ready_when_tail_free: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s5 |-> pix_in.ready)
		else $error("input stalled with empty output stage");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted beat did not reach stage 1");

	a_stall_holds_s3: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !ld.s4 |=> v_s3)
		else $error("stalled beat lost in stage 3");

	a_masked_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid && m0_s5 |-> pix_out.red0 == 8'd0 && pix_out.blue0 == 8'd0 &&
		(pix_out.green0 == 8'd0 || pix_out.green0 == CHAN_MAX))
		else $error("masked pixel is neither green nor black");

endmodule

// File: tb/tb_top.sv
// self-checking testbench for yuyv_to_rgb_red_mask_core: directed table then random yuyv words
// predicts the rgb pixel pair of each untyped word in bt.601 integer math with the sparse red mask
// depends on yrm_pkg, yrm_if and the core rtl
`timescale 1ns / 100ps

module tb_top;
	import yrm_pkg::*;

	localparam int RANDOM_WORDS = 1600;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 4 * NSTAGE;
	localparam int HOLD_CYCLES  = 64;

	typedef struct {
		logic [7:0] luma0;
		logic [7:0] chroma_u;
		logic [7:0] luma1;
		logic [7:0] chroma_v;
		logic [9:0] column;
		logic [8:0] row;
	} yuyv_word_t;

	typedef struct packed {
		rgb_t px0;
		rgb_t px1;
	} pixel_pair_t;

	typedef struct {
		yuyv_word_t  word;
		bit          typed;
		pixel_pair_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	yrm_in_if  pix_in_bus ();
	yrm_out_if pix_out_bus ();

	yuyv_to_rgb_red_mask_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in_bus),
		.pix_out (pix_out_bus)
	);

	pixel_pair_t expected_pairs[$];
	stim_row_t   stim_rows[$];
	int          errors;
	int          words_sent;
	bit          gaps_on;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [7:0] chan_clamp(input int acc);
		int q;
		q = acc >>> 8;
		if (q < 0)
			return 8'd0;
		if (q > 255)
			return CHAN_MAX;
		return q[7:0];
	endfunction

	function automatic bit looks_red(input rgb_t px);
		int r;
		int g;
		int b;
		r = int'(px.red);
		g = int'(px.green);
		b = int'(px.blue);
		if (r >= 115 && g <= 63 && b <= 63)
			return 1'b1;
		if (9 * r * r <= 4 * (g * g + b * b))
			return 1'b0;
		if (10 * r + 4 * b - 10 * g <= 1275)
			return 1'b0;
		if (10 * r + 4 * g - 10 * b <= 1275)
			return 1'b0;
		return 1'b1;
	endfunction

	function automatic rgb_t convert_px(input logic [7:0] y, input int d, input int e,
		input int col, input int row);
		rgb_t px;
		int   c;
		c = int'(y) - 16;
		px.red   = chan_clamp(298 * c + 409 * e + 128);
		px.green = chan_clamp(298 * c - 100 * d - 208 * e + 128);
		px.blue  = chan_clamp(298 * c + 516 * d + 128);
		if ((col % 3) != 0 && (row % 3) != 0)
			px = looks_red(px) ? {8'd0, CHAN_MAX, 8'd0} : 24'd0;
		return px;
	endfunction

	function automatic pixel_pair_t predict_pair(input yuyv_word_t w);
		pixel_pair_t pp;
		int          d;
		int          e;
		d = int'(w.chroma_u) - 128;
		e = int'(w.chroma_v) - 128;
		pp.px0 = convert_px(w.luma0, d, e, int'(w.column), int'(w.row));
		pp.px1 = convert_px(w.luma1, d, e, int'(w.column) + 1, int'(w.row));
		return pp;
	endfunction

	task automatic add_row(input logic [7:0] y0, input logic [7:0] u, input logic [7:0] y1,
		input logic [7:0] v, input logic [9:0] col, input logic [8:0] row,
		input bit typed, input pixel_pair_t want);
		stim_row_t sr;
		sr.word = '{luma0: y0, chroma_u: u, luma1: y1, chroma_v: v, column: col, row: row};
		sr.typed = typed;
		sr.want = want;
		stim_rows.push_back(sr);
	endtask

	// one beat on the input channel, with random gaps ahead of it when gaps_on is set
	task automatic send_word(input yuyv_word_t w, input bit typed, input pixel_pair_t want);
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < 33) begin
			pix_in_bus.valid <= 1'b0;
			@(negedge clk);
		end
		pix_in_bus.valid    <= 1'b1;
		pix_in_bus.luma0    <= w.luma0;
		pix_in_bus.chroma_u <= w.chroma_u;
		pix_in_bus.luma1    <= w.luma1;
		pix_in_bus.chroma_v <= w.chroma_v;
		pix_in_bus.column   <= w.column;
		pix_in_bus.row      <= w.row;
		do
			@(posedge clk);
		while (!pix_in_bus.ready);
		expected_pairs.push_back(typed ? want : predict_pair(w));
		words_sent++;
	endtask

	task automatic check_chan(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	initial begin
		yuyv_word_t w;
		int         pick;
		arst_n = 1'b0;
		errors = 0;
		words_sent = 0;
		gaps_on = 1'b1;
		pix_in_bus.valid    = 1'b0;
		pix_in_bus.luma0    = '0;
		pix_in_bus.chroma_u = '0;
		pix_in_bus.luma1    = '0;
		pix_in_bus.chroma_v = '0;
		pix_in_bus.column   = '0;
		pix_in_bus.row      = '0;

		// black, white, clamping at both ends, pure red, mask on red and non-red
		add_row(8'd16, 8'd128, 8'd16, 8'd128, 10'd0, 9'd0, 1'b1, 48'h000000_000000);
		add_row(8'd235, 8'd128, 8'd235, 8'd128, 10'd0, 9'd0, 1'b1, 48'hFFFFFF_FFFFFF);
		add_row(8'd0, 8'd128, 8'd0, 8'd128, 10'd0, 9'd0, 1'b1, 48'h000000_000000);
		add_row(8'd255, 8'd128, 8'd255, 8'd128, 10'd0, 9'd0, 1'b1, 48'hFFFFFF_FFFFFF);
		add_row(8'd81, 8'd90, 8'd81, 8'd240, 10'd0, 9'd0, 1'b1, 48'hFF0000_FF0000);
		add_row(8'd81, 8'd90, 8'd81, 8'd240, 10'd4, 9'd1, 1'b1, 48'h00FF00_00FF00);
		add_row(8'd235, 8'd128, 8'd235, 8'd128, 10'd4, 9'd1, 1'b1, 48'h000000_000000);
		add_row(8'd81, 8'd90, 8'd81, 8'd240, 10'd2, 9'd1, 1'b1, 48'h00FF00_FF0000);
		// chroma corners and mixed lumas
		add_row(8'd0, 8'd0, 8'd255, 8'd0, 10'd6, 9'd3, 1'b0, '0);
		add_row(8'd255, 8'd255, 8'd0, 8'd255, 10'd8, 9'd4, 1'b0, '0);
		add_row(8'd128, 8'd0, 8'd128, 8'd255, 10'd10, 9'd5, 1'b0, '0);
		add_row(8'd128, 8'd255, 8'd128, 8'd0, 10'd14, 9'd7, 1'b0, '0);
		add_row(8'd60, 8'd100, 8'd110, 8'd200, 10'd16, 9'd8, 1'b0, '0);
		add_row(8'd90, 8'd110, 8'd70, 8'd190, 10'd20, 9'd10, 1'b0, '0);
		// field extremes, odd column, outside the frame
		add_row(8'd255, 8'd255, 8'd255, 8'd255, 10'd1023, 9'd511, 1'b0, '0);
		add_row(8'd81, 8'd90, 8'd81, 8'd240, 10'd1023, 9'd511, 1'b0, '0);
		add_row(8'd81, 8'd90, 8'd81, 8'd240, 10'd1, 9'd2, 1'b0, '0);
		add_row(8'd81, 8'd90, 8'd81, 8'd240, 10'd700, 9'd500, 1'b0, '0);
		add_row(8'd100, 8'd128, 8'd200, 8'd128, 10'd638, 9'd479, 1'b0, '0);
		add_row(8'd81, 8'd90, 8'd81, 8'd240, 10'd637, 9'd478, 1'b0, '0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (stim_rows[i])
			send_word(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].want);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			gaps_on = !(n >= 600 && n < 900);
			if (n == 1200) begin
				@(negedge clk);
				pix_in_bus.valid <= 1'b0;
				while (expected_pairs.size() != 0)
					@(negedge clk);
			end
			pick = $urandom_range(99);
			if (pick < 40) begin
				// reddish region so both red rules and their borders get hit
				w.luma0    = 8'($urandom_range(160, 30));
				w.luma1    = 8'($urandom_range(160, 30));
				w.chroma_u = 8'($urandom_range(140, 50));
				w.chroma_v = 8'($urandom_range(255, 150));
			end else begin
				w.luma0    = 8'($urandom_range(255));
				w.luma1    = 8'($urandom_range(255));
				w.chroma_u = 8'($urandom_range(255));
				w.chroma_v = 8'($urandom_range(255));
			end
			if ($urandom_range(99) < 70) begin
				w.column = 10'(2 * $urandom_range(319));
				w.row    = 9'($urandom_range(479));
			end else begin
				w.column = 10'($urandom_range(1023));
				w.row    = 9'($urandom_range(511));
			end
			send_word(w, 1'b0, '0);
		end
		gaps_on = 1'b1;
		@(negedge clk);
		pix_in_bus.valid <= 1'b0;

		while (expected_pairs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// result side ready, with one long hold-off to back the pipeline up
	initial begin
		bit held;
		held = 1'b0;
		pix_out_bus.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!held && words_sent >= 300) begin
				held = 1'b1;
				pix_out_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				pix_out_bus.ready <= !gaps_on || ($urandom_range(99) >= 33);
			end
		end
	end

	always @(posedge clk) begin
		pixel_pair_t want;
		if (arst_n && pix_out_bus.valid && pix_out_bus.ready) begin
			if (expected_pairs.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat expected none actual %h %h %h %h %h %h",
					$time, pix_out_bus.red0, pix_out_bus.green0, pix_out_bus.blue0,
					pix_out_bus.red1, pix_out_bus.green1, pix_out_bus.blue1);
			end else begin
				want = expected_pairs.pop_front();
				check_chan("red0", want.px0.red, pix_out_bus.red0);
				check_chan("green0", want.px0.green, pix_out_bus.green0);
				check_chan("blue0", want.px0.blue, pix_out_bus.blue0);
				check_chan("red1", want.px1.red, pix_out_bus.red1);
				check_chan("green1", want.px1.green, pix_out_bus.green1);
				check_chan("blue1", want.px1.blue, pix_out_bus.blue1);
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if ((pix_in_bus.valid && pix_in_bus.ready) ||
				(pix_out_bus.valid && pix_out_bus.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: timeout, no beat for %0d cycles", $time, idle_cycles);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

endmodule

// File: sim.f
rtl/yrm_pkg.sv
rtl/yrm_if.sv
rtl/yrm_convert.sv
rtl/yrm_red_mask.sv
rtl/yuyv_to_rgb_red_mask_core.sv
tb/tb_top.sv
